// ----- rtl/tdpc_pkg.sv -----
// package for the threshold distinct point counter: sizes, codes, types
// and the command and status bundles between controller and datapath
// no dependencies
package tdpc_pkg;

   // sizing
   localparam int MAX_POINTS  = 4096;
   localparam int MAX_DIM     = 32;
   localparam int COORD_WIDTH = 16;

   // fixed field widths
   localparam int DIM_W   = 6;
   localparam int THR_W   = 40;
   localparam int CNT_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 40;

   // derived widths
   localparam int ROW_W   = $clog2(MAX_POINTS);
   localparam int K_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PC_W    = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = ROW_W + K_W;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int SQ_W    = 2 * COORD_WIDTH;
   localparam int ACC_W   = SQ_W + PC_W;
   localparam int CMP_W   = (ACC_W > THR_W) ? ACC_W : THR_W;
   localparam int MEM_DEPTH = MAX_POINTS * (2 ** K_W);

   // reset values of the registers
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(25600);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_STORE,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // input item accepted
      logic walk_start;  // point complete: restart row walk
      logic issue;       // read one stored coordinate
      logic next_row;    // move to next stored row
      logic mark_dup;    // close representative found
      logic store;       // write one coordinate of the new row
      logic set_full;    // new point found no room
      logic result;      // load output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_k;      // current coordinate is the last of the point
      logic last_store;  // current coordinate is the last of a row
      logic row_done;    // distance of a row just finished
      logic hit;         // that distance is below threshold
      logic last_row;    // current row is the last stored row
      logic empty;       // no representatives stored
      logic room;        // store has a free row
      logic out_free;    // output register can take a result
   } status_type;

endpackage

// ----- rtl/tdpc_if.sv -----
// channel interfaces of the threshold distinct point counter
// depends on tdpc_pkg
interface tdpc_req_if;
   logic                 valid;
   logic                 ready;
   tdpc_pkg::coord_type  coord;
   logic                 point_end;
   logic                 set_end;

   modport source (output valid, output coord, output point_end, output set_end,
                   input ready);
   modport sink   (input valid, input coord, input point_end, input set_end,
                   output ready);
endinterface

interface tdpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       is_new;
   logic [tdpc_pkg::CNT_W-1:0] count;
   logic                       store_full;
   logic                       final_res;

   modport source (output valid, output is_new, output count, output store_full,
                   output final_res, input ready);
   modport sink   (input valid, input is_new, input count, input store_full,
                   input final_res, output ready);
endinterface

interface tdpc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tdpc_pkg::CSR_IDX_W-1:0] index;
   logic [tdpc_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tdpc_datapath.sv -----
// datapath: pending point, representative memory, distance pipeline,
// counters, configuration registers and output register
// depends on tdpc_pkg
module tdpc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tdpc_pkg::cmd_type             cmd,
   output tdpc_pkg::status_type          status,
   input  tdpc_pkg::coord_type           req_coord,
   input  logic                          req_set_end,
   input  logic                          csr_we,
   input  logic [tdpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tdpc_pkg::CSR_DAT_W-1:0] csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_new,
   output logic [tdpc_pkg::CNT_W-1:0]    rsp_count,
   output logic                          rsp_store_full,
   output logic                          rsp_final_res
);

   // configuration
   logic [tdpc_pkg::DIM_W-1:0] dim_ff;
   logic [tdpc_pkg::THR_W-1:0] thr_ff;
   logic [tdpc_pkg::PC_W-1:0]  eff_n;

   // walk and point state
   tdpc_pkg::coord_type         pend_ff [tdpc_pkg::MAX_DIM];
   logic [tdpc_pkg::PC_W-1:0]   coord_cnt_ff;
   logic [tdpc_pkg::ROW_W-1:0]  row_ff;
   logic [tdpc_pkg::K_W-1:0]    k_ff;
   logic [tdpc_pkg::CNT_W-1:0]  rep_cnt_ff;
   logic                        full_ff;
   logic                        dup_ff;
   logic                        final_ff;
   tdpc_pkg::coord_type         pend_sel;

   // memory
   tdpc_pkg::coord_type         mem [tdpc_pkg::MEM_DEPTH];
   logic [tdpc_pkg::ADDR_W-1:0] addr;
   tdpc_pkg::coord_type         rd_data_ff;

   // distance pipeline
   tdpc_pkg::coord_type              pend_q_ff;
   logic                             v1_ff, v2_ff, v3_ff;
   logic                             last1_ff, last2_ff, last3_ff;
   logic signed [tdpc_pkg::DIFF_W-1:0]   diff_ff;
   logic signed [2*tdpc_pkg::DIFF_W-1:0] prod;
   logic [tdpc_pkg::SQ_W-1:0]        sq_ff;
   logic [tdpc_pkg::ACC_W-1:0]       acc_ff;
   logic [tdpc_pkg::ACC_W-1:0]       acc_sum;
   logic                             row_done_ff;
   logic                             hit_ff;

   // output register
   logic                             rsp_valid_ff;
   logic                             rsp_is_new_ff;
   logic [tdpc_pkg::CNT_W-1:0]       rsp_count_ff;
   logic                             rsp_full_ff;
   logic                             rsp_final_ff;

   // effective dimension: zero acts as one, large values clamp
   always_comb begin
      if (dim_ff == '0) begin
         eff_n = tdpc_pkg::PC_W'(1);
      end else if (int'(dim_ff) > tdpc_pkg::MAX_DIM) begin
         eff_n = tdpc_pkg::PC_W'(tdpc_pkg::MAX_DIM);
      end else begin
         eff_n = tdpc_pkg::PC_W'(dim_ff);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= tdpc_pkg::DIM_RESET;
         thr_ff <= tdpc_pkg::THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tdpc_pkg::CSR_DIMENSION: dim_ff <= csr_data[tdpc_pkg::DIM_W-1:0];
            tdpc_pkg::CSR_THRESHOLD: thr_ff <= csr_data[tdpc_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // pending coordinate, zero where not received in this point
   assign pend_sel = (tdpc_pkg::PC_W'(k_ff) < coord_cnt_ff) ? pend_ff[k_ff] : '0;

   // pending point capture
   always_ff @(posedge clock) begin
      if (cmd.take && (coord_cnt_ff < eff_n)) begin
         pend_ff[coord_cnt_ff[tdpc_pkg::K_W-1:0]] <= req_coord;
      end
   end

   // point and walk control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_cnt_ff <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         rep_cnt_ff   <= '0;
         full_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         if (cmd.take && (coord_cnt_ff < eff_n)) begin
            coord_cnt_ff <= coord_cnt_ff + tdpc_pkg::PC_W'(1);
         end
         if (cmd.walk_start) begin
            row_ff   <= '0;
            k_ff     <= '0;
            dup_ff   <= 1'b0;
            final_ff <= req_set_end;
         end
         if (cmd.issue) begin
            k_ff <= status.last_k ? '0 : k_ff + tdpc_pkg::K_W'(1);
         end
         if (cmd.next_row) begin
            row_ff <= row_ff + tdpc_pkg::ROW_W'(1);
         end
         if (cmd.mark_dup) begin
            dup_ff <= 1'b1;
         end
         if (cmd.store) begin
            k_ff <= status.last_store ? '0 : k_ff + tdpc_pkg::K_W'(1);
            if (status.last_store) begin
               rep_cnt_ff <= rep_cnt_ff + tdpc_pkg::CNT_W'(1);
            end
         end
         if (cmd.set_full) begin
            full_ff <= 1'b1;
         end
         // point closed: clear pending, and the set after its last point
         if (cmd.result) begin
            coord_cnt_ff <= '0;
            if (final_ff) begin
               rep_cnt_ff <= '0;
               full_ff    <= 1'b0;
            end
         end
      end
   end

   // representative memory, one port
   assign addr = cmd.store ? {rep_cnt_ff[tdpc_pkg::ROW_W-1:0], k_ff} : {row_ff, k_ff};

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[addr] <= pend_sel;
      end
      rd_data_ff <= mem[addr];
      pend_q_ff  <= pend_sel;
   end

   // difference, square, accumulate
   assign prod    = diff_ff * diff_ff;
   assign acc_sum = acc_ff + tdpc_pkg::ACC_W'(sq_ff);

   always_ff @(posedge clock) begin
      diff_ff <= tdpc_pkg::DIFF_W'(rd_data_ff) - tdpc_pkg::DIFF_W'(pend_q_ff);
      sq_ff   <= prod[tdpc_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         last1_ff    <= 1'b0;
         last2_ff    <= 1'b0;
         last3_ff    <= 1'b0;
         acc_ff      <= '0;
         row_done_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         v1_ff       <= cmd.issue;
         last1_ff    <= cmd.issue && status.last_k;
         v2_ff       <= v1_ff;
         last2_ff    <= last1_ff;
         v3_ff       <= v2_ff;
         last3_ff    <= last2_ff;
         row_done_ff <= v3_ff && last3_ff;
         if (v3_ff) begin
            if (last3_ff) begin
               acc_ff <= '0;
               hit_ff <= tdpc_pkg::CMP_W'(acc_sum) < tdpc_pkg::CMP_W'(thr_ff);
            end else begin
               acc_ff <= acc_sum;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_is_new_ff <= !dup_ff;
         rsp_count_ff  <= rep_cnt_ff;
         rsp_full_ff   <= full_ff;
         rsp_final_ff  <= final_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_new     = rsp_is_new_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_store_full = rsp_full_ff;
   assign rsp_final_res  = rsp_final_ff;

   // status to the controller
   always_comb begin
      status.last_k     = tdpc_pkg::PC_W'(k_ff) == (eff_n - tdpc_pkg::PC_W'(1));
      status.last_store = int'(k_ff) == (tdpc_pkg::MAX_DIM - 1);
      status.row_done   = row_done_ff;
      status.hit        = hit_ff;
      status.last_row   = (tdpc_pkg::CNT_W'(row_ff) + tdpc_pkg::CNT_W'(1)) == rep_cnt_ff;
      status.empty      = rep_cnt_ff == '0;
      status.room       = rep_cnt_ff < tdpc_pkg::CNT_W'(tdpc_pkg::MAX_POINTS);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rep_cnt_ff <= tdpc_pkg::CNT_W'(tdpc_pkg::MAX_POINTS))
      else $error("representative count above store size");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.result && final_ff) |=> (rep_cnt_ff == '0) && !full_ff)
      else $error("set not emptied after its last point");

   a_store_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && status.last_store) |=>
         rep_cnt_ff == $past(rep_cnt_ff) + tdpc_pkg::CNT_W'(1))
      else $error("stored row not counted");
`endif

endmodule

// ----- rtl/tdpc_controller.sv -----
// controller: sequences item intake, the row walk, the row copy and
// the result hand-off
// depends on tdpc_pkg
module tdpc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_point_end,
   output logic                 req_ready,
   input  tdpc_pkg::status_type status,
   output tdpc_pkg::cmd_type    cmd
);

   tdpc_pkg::state_type state_ff;
   tdpc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdpc_pkg::ST_IDLE: begin
            if (req_valid && req_point_end) begin
               state_in = status.empty ? tdpc_pkg::ST_STORE : tdpc_pkg::ST_ISSUE;
            end
         end
         tdpc_pkg::ST_ISSUE: begin
            if (status.last_k) begin
               state_in = tdpc_pkg::ST_DRAIN;
            end
         end
         tdpc_pkg::ST_DRAIN: begin
            if (status.row_done) begin
               if (status.hit) begin
                  state_in = tdpc_pkg::ST_RESULT;
               end else if (!status.last_row) begin
                  state_in = tdpc_pkg::ST_ISSUE;
               end else if (status.room) begin
                  state_in = tdpc_pkg::ST_STORE;
               end else begin
                  state_in = tdpc_pkg::ST_RESULT;
               end
            end
         end
         tdpc_pkg::ST_STORE: begin
            if (status.last_store) begin
               state_in = tdpc_pkg::ST_RESULT;
            end
         end
         tdpc_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = tdpc_pkg::ST_IDLE;
            end
         end
         default: state_in = tdpc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tdpc_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.take       = req_valid;
            cmd.walk_start = req_valid && req_point_end;
         end
         tdpc_pkg::ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         tdpc_pkg::ST_DRAIN: begin
            cmd.mark_dup = status.row_done && status.hit;
            cmd.next_row = status.row_done && !status.hit && !status.last_row;
            cmd.set_full = status.row_done && !status.hit && status.last_row &&
                           !status.room;
         end
         tdpc_pkg::ST_STORE: begin
            cmd.store = 1'b1;
         end
         tdpc_pkg::ST_RESULT: begin
            cmd.result = status.out_free;
         end
         default: ;
      endcase
   end

`ifndef ASSERT_OFF
   a_issue_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdpc_pkg::ST_ISSUE && status.last_k) |=>
         state_ff == tdpc_pkg::ST_DRAIN)
      else $error("row walk did not wait for its distance");

   a_row_done_drain: assert property (@(posedge clock) disable iff (reset)
      status.row_done |-> state_ff == tdpc_pkg::ST_DRAIN)
      else $error("row distance arrived outside the drain wait");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.result |=> state_ff == tdpc_pkg::ST_IDLE)
      else $error("result given without returning to intake");
`endif

endmodule

// ----- rtl/threshold_distinct_point_counter.sv -----
// top level of the threshold distinct point counter
// depends on tdpc_pkg, tdpc_if, tdpc_controller, tdpc_datapath
//
// usage
//   req_if carries one coordinate per item (signed Q11.4) with point_end on
//   the last coordinate of a point and set_end on the last point of a set.
//   rsp_if gives one result per completed point: is_new, count, store_full
//   and final_res. csr_if is always ready and writes dimension (index 0)
//   and threshold (index 1). write it only while the block idles; it is not enforced.
// walk and hand-off
//   an item without point_end is accepted in the idle state. a completed
//   point walks the stored rows through the single port of the
//   representative memory, one row after another; a new point with room
//   is then copied into every coordinate slot of its row, and the result
//   is loaded into the output register in the result state once that
//   register is free. intake waits until that hand-off.
// reset and stall
//   reset empties the set, clears the pending point and loads dimension 2
//   and threshold 25600. the output register holds a result while rsp_if
//   stalls; intake goes on, and a second completed point waits at its
//   hand-off until the register frees.
module threshold_distinct_point_counter (
   input  logic       clock,
   input  logic       reset,
   tdpc_req_if.sink   req_if,
   tdpc_rsp_if.source rsp_if,
   tdpc_csr_if.sink   csr_if
);

   tdpc_pkg::cmd_type    cmd;
   tdpc_pkg::status_type status;
   logic                 req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   tdpc_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_point_end (req_if.point_end),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   tdpc_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_coord      (req_if.coord),
      .req_set_end    (req_if.set_end),
      .csr_we         (csr_if.valid),
      .csr_index      (csr_if.index),
      .csr_data       (csr_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_is_new     (rsp_if.is_new),
      .rsp_count      (rsp_if.count),
      .rsp_store_full (rsp_if.store_full),
      .rsp_final_res  (rsp_if.final_res)
   );

endmodule

// ----- dv/tb.sv -----
// testbench for threshold_distinct_point_counter: directed and random points
// checked against an in-bench prediction of the representative store
// depends on tdpc_pkg, tdpc_if and the rtl of the block
`timescale 1ns / 100ps

module tb;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RANDOM_ITEMS  = 580;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int RING_DEPTH    = 8;

   // register index with no register behind it
   localparam logic [tdpc_pkg::CSR_IDX_W-1:0] CSR_SPARE = tdpc_pkg::CSR_IDX_W'(3);

   typedef struct packed {
      logic                       is_new;
      logic [tdpc_pkg::CNT_W-1:0] count;
      logic                       store_full;
      logic                       final_res;
   } verdict_type;

   // predicted representative store and queue of verdicts still to arrive
   class cluster_scoreboard;
      tdpc_pkg::coord_type        rows[tdpc_pkg::MAX_POINTS][tdpc_pkg::MAX_DIM];
      tdpc_pkg::coord_type        pending_pt[tdpc_pkg::MAX_DIM];
      int unsigned                row_count;
      int unsigned                fill;
      bit                         overflow;
      logic [tdpc_pkg::DIM_W-1:0] dim_reg;
      logic [tdpc_pkg::THR_W-1:0] thr_reg;
      verdict_type                verdicts_due[$];
      int unsigned                mismatches;

      function new();
         foreach (pending_pt[k]) pending_pt[k] = '0;
         row_count  = 0;
         fill       = 0;
         overflow   = 1'b0;
         dim_reg    = tdpc_pkg::DIM_RESET;
         thr_reg    = tdpc_pkg::THR_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [tdpc_pkg::CSR_IDX_W-1:0] idx,
                              logic [tdpc_pkg::CSR_DAT_W-1:0] data);
         if (idx == tdpc_pkg::CSR_DIMENSION) dim_reg = data[tdpc_pkg::DIM_W-1:0];
         else if (idx == tdpc_pkg::CSR_THRESHOLD) thr_reg = data[tdpc_pkg::THR_W-1:0];
      endfunction

      // dimension in force: zero acts as one, oversize clips to the row width
      function int unsigned span();
         if (dim_reg == 0) return 1;
         if (dim_reg > tdpc_pkg::MAX_DIM) return tdpc_pkg::MAX_DIM;
         return dim_reg;
      endfunction

      function longint unsigned distance_to(int unsigned r, int unsigned n);
         longint unsigned acc;
         longint          d;
         acc = 0;
         for (int unsigned k = 0; k < n; k++) begin
            d   = rows[r][k];
            d   = d - pending_pt[k];
            acc = acc + d * d;
         end
         return acc;
      endfunction

      function int unsigned pending();
         return verdicts_due.size();
      endfunction

      // one accepted coordinate; a completed point queues its verdict
      function void note_coord(tdpc_pkg::coord_type c, logic last_coord, logic last_point);
         int unsigned n;
         bit          fresh;
         verdict_type v;
         n = span();
         if (fill < n) begin
            pending_pt[fill] = c;
            fill++;
         end
         if (!last_coord) return;
         // walk stored rows, stop at the first one strictly inside threshold
         fresh = 1'b1;
         for (int unsigned r = 0; r < row_count && fresh; r++)
            if (distance_to(r, n) < thr_reg) fresh = 1'b0;
         if (fresh) begin
            if (row_count < tdpc_pkg::MAX_POINTS) begin
               rows[row_count] = pending_pt;
               row_count++;
            end else begin
               overflow = 1'b1;
            end
         end
         v.is_new     = fresh;
         v.count      = tdpc_pkg::CNT_W'(row_count);
         v.store_full = overflow;
         v.final_res  = last_point;
         verdicts_due.push_back(v);
         // missing coordinates of the next point read as zero
         foreach (pending_pt[k]) pending_pt[k] = '0;
         fill = 0;
         if (last_point) begin
            row_count = 0;
            overflow  = 1'b0;
         end
      endfunction

      function string fields_text(verdict_type v);
         return $sformatf("is_new %0b count %0d store_full %0b final_res %0b",
                          v.is_new, v.count, v.store_full, v.final_res);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing expected: %s", fields_text(got));
            return;
         end
         want = verdicts_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %s, got %s",
                        fields_text(want), fields_text(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tdpc_req_if req_if ();
   tdpc_rsp_if rsp_if ();
   tdpc_csr_if csr_if ();

   threshold_distinct_point_counter u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   cluster_scoreboard sb;
   bit                no_gaps;
   int unsigned       hold_req;
   int unsigned       hold_left;
   int unsigned       items_done;
   longint unsigned   cycle_count;

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(99) < 33);
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !take_gap();
         end
      end
   end

   // accepted results
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_verdict(verdict_type'{rsp_if.is_new, rsp_if.count,
                                        rsp_if.store_full, rsp_if.final_res});
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // raise a register write and wait for it; the caller drops valid
   task automatic csr_write(input logic [tdpc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tdpc_pkg::CSR_DAT_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
   endtask

   // dimension goes out with random upper bits, which the register drops
   task automatic configure(input logic [tdpc_pkg::DIM_W-1:0] dim,
                            input logic [tdpc_pkg::THR_W-1:0] thr);
      logic [tdpc_pkg::CSR_DAT_W-1:0] word;
      word = tdpc_pkg::CSR_DAT_W'({$urandom, $urandom});
      word[tdpc_pkg::DIM_W-1:0] = dim;
      csr_write(tdpc_pkg::CSR_DIMENSION, word);
      csr_write(tdpc_pkg::CSR_THRESHOLD, tdpc_pkg::CSR_DAT_W'(thr));
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_coord(input tdpc_pkg::coord_type c, input logic last_coord,
                             input logic last_point);
      while (take_gap()) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.coord     <= c;
      req_if.point_end <= last_coord;
      req_if.set_end   <= last_point;
      do @(posedge clock); while (!req_if.ready);
      sb.note_coord(c, last_coord, last_point);
   endtask

   // one point of len items; inner items now and then carry a stray set_end
   task automatic send_point(input tdpc_pkg::coord_type pt[tdpc_pkg::MAX_DIM],
                             input int unsigned len, input int unsigned n,
                             input logic closing);
      tdpc_pkg::coord_type c;
      logic                last;
      for (int unsigned k = 0; k < len; k++) begin
         c    = (k < tdpc_pkg::MAX_DIM) ? pt[k] : tdpc_pkg::coord_type'($urandom);
         last = (k + 1 == len);
         send_coord(c, last, last ? closing : ($urandom_range(99) < 5));
         if (k < n || last) items_done++;
      end
   endtask

   // wait until every expected result is in and the block has gone quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned                set_no;
      int unsigned                points;
      int unsigned                n;
      int unsigned                len;
      int unsigned                roll;
      int unsigned                pick;
      int unsigned                ring_wr;
      int unsigned                ring_fill;
      int unsigned                ring_used;
      logic [tdpc_pkg::DIM_W-1:0] dim;
      logic [tdpc_pkg::THR_W-1:0] thr;
      bit                         closing;
      bit                         near;
      tdpc_pkg::coord_type        pt[tdpc_pkg::MAX_DIM];
      tdpc_pkg::coord_type        ring[RING_DEPTH][tdpc_pkg::MAX_DIM];

      sb               = new();
      no_gaps          = 1'b0;
      hold_req         = 0;
      items_done       = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.coord     = '0;
      req_if.point_end = 1'b0;
      req_if.set_end   = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings, written back explicitly after a write to the spare index
      csr_write(CSR_SPARE, tdpc_pkg::CSR_DAT_W'({$urandom, $urandom}));
      configure(tdpc_pkg::DIM_RESET, tdpc_pkg::THR_RESET);
      // coordinate extremes, then a near copy of the first point
      send_coord(tdpc_pkg::coord_type'(32767), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(-32768), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(-32768), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(32767), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(32767), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(-32767), 1'b1, 1'b0);
      // short point: second coordinate reads as zero
      send_coord(tdpc_pkg::coord_type'(5), 1'b1, 1'b0);
      // long point: coordinates past the dimension are dropped
      send_coord(tdpc_pkg::coord_type'(0), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(0), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(999), 1'b0, 1'b0);
      send_coord(tdpc_pkg::coord_type'(1234), 1'b1, 1'b0);
      // set_end without point_end is ignored, the next one closes the set
      send_coord(tdpc_pkg::coord_type'(3), 1'b0, 1'b1);
      send_coord(tdpc_pkg::coord_type'(4), 1'b1, 1'b1);
      settle();

      // zero threshold: even identical points are new
      configure(tdpc_pkg::DIM_W'(1), '0);
      send_coord(tdpc_pkg::coord_type'(7), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(7), 1'b1, 1'b0);
      settle();

      // oversize dimension mid-set and the largest threshold
      configure('1, '1);
      send_coord(tdpc_pkg::coord_type'(-1), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(0), 1'b1, 1'b1);
      settle();

      // dimension zero acts as one; threshold one separates distance 0 from 1
      configure('0, tdpc_pkg::THR_W'(1));
      send_coord(tdpc_pkg::coord_type'(100), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(100), 1'b1, 1'b0);
      send_coord(tdpc_pkg::coord_type'(101), 1'b1, 1'b1);

      // random sets, mostly well-formed points, many near earlier ones
      set_no    = 0;
      ring_wr   = 0;
      ring_fill = 0;
      while (items_done < RANDOM_ITEMS) begin
         settle();
         roll = $urandom_range(99);
         if (roll < 55) dim = tdpc_pkg::DIM_W'($urandom_range(1, 3));
         else if (roll < 80) dim = tdpc_pkg::DIM_W'($urandom_range(4, 8));
         else if (roll < 92) dim = tdpc_pkg::DIM_W'($urandom_range(9, tdpc_pkg::MAX_DIM));
         else if (roll < 96) dim = '0;
         else dim = tdpc_pkg::DIM_W'($urandom_range(tdpc_pkg::MAX_DIM + 1, 63));
         if (set_no == 2) dim = tdpc_pkg::DIM_W'(2);
         if (set_no == 3) dim = tdpc_pkg::DIM_W'(1);
         if (set_no == 4) dim = tdpc_pkg::DIM_W'(tdpc_pkg::MAX_DIM);
         roll = $urandom_range(99);
         if (roll < 10) thr = '0;
         else if (roll < 20) thr = '1;
         else if (roll < 60) thr = tdpc_pkg::THR_W'($urandom_range(0, 4096));
         else thr = tdpc_pkg::THR_W'({$urandom, $urandom} >> $urandom_range(24, 63));
         configure(dim, thr);
         n = sb.span();

         no_gaps = (set_no >= 6 && set_no < 10);
         points  = $urandom_range(1, 12);
         // result side holds off while a full set keeps coming
         if (set_no == 2) begin
            points   = 10;
            hold_req = HOLD_CYCLES;
         end
         // an open set carries over into the next dimension
         closing = ($urandom_range(99) < 75);

         for (int unsigned p = 0; p < points; p++) begin
            near      = (ring_fill != 0) && ($urandom_range(99) < 50);
            ring_used = (ring_fill < RING_DEPTH) ? ring_fill : RING_DEPTH;
            if (near) pick = $urandom_range(0, ring_used - 1);
            for (int unsigned k = 0; k < tdpc_pkg::MAX_DIM; k++) begin
               if (near)
                  pt[k] = tdpc_pkg::coord_type'(ring[pick][k] + $urandom_range(0, 16) - 8);
               else if ($urandom_range(1))
                  pt[k] = tdpc_pkg::coord_type'($urandom);
               else
                  pt[k] = tdpc_pkg::coord_type'($urandom_range(0, 400) - 200);
            end
            roll = $urandom_range(99);
            if (roll < 10 && n > 1) len = $urandom_range(1, n - 1);
            else if (roll < 16) len = n + $urandom_range(1, 3);
            else len = n;
            send_point(pt, len, n, closing && (p + 1 == points));
            ring[ring_wr] = pt;
            ring_wr       = (ring_wr + 1) % RING_DEPTH;
            ring_fill++;
         end
         set_no++;
      end
      no_gaps = 1'b0;

      settle();
      if (sb.mismatches == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tdpc_pkg.sv
rtl/tdpc_if.sv
rtl/tdpc_datapath.sv
rtl/tdpc_controller.sv
rtl/threshold_distinct_point_counter.sv
dv/tb.sv
